// File: hw/rtl/bra_pkg.sv
// Shared types, field widths and codes of the band-limited step correction mixer.
package bra_pkg;

  localparam int REQ_W  = 2;
  localparam int AMP_W  = 18;
  localparam int POS_W  = 16;
  localparam int KIND_W = 2;
  localparam int ROW_W  = 7;
  localparam int TAP_W  = 6;
  localparam int VAL_W  = 24;
  localparam int SMP_W  = 32;
  localparam int FRAC_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_STEP  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IMPULSE  = 2'd0,
    KIND_STEP     = 2'd1,
    KIND_RAMP     = 2'd2,
    KIND_STEP_ALT = 2'd3
  } table_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SETUP,
    ST_ADD,
    ST_DRAIN,
    ST_STEP
  } state_t;

  // The fourth kind code selects the step table.
  function automatic logic [KIND_W-1:0] kind_sel(input logic [KIND_W-1:0] kind);
    logic [KIND_W-1:0] k;
    k = kind;
    if (table_kind_t'(kind) == KIND_STEP_ALT) begin
      k = KIND_STEP;
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/bra_if.sv
// Request and sample channel interfaces with valid/ready handshake.
interface bra_req_if import bra_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [AMP_W-1:0]  amplitude;
  logic [POS_W-1:0]         position;
  logic [KIND_W-1:0]        kind;
  logic [ROW_W-1:0]         table_row;
  logic [TAP_W-1:0]         table_tap;
  logic signed [VAL_W-1:0]  table_value;

  modport source (
    output valid, req_type, amplitude, position, kind, table_row, table_tap, table_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, amplitude, position, kind, table_row, table_tap, table_value,
    output ready
  );
endinterface

interface bra_smp_if import bra_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

// File: hw/rtl/bra_ram.sv
// Generic RAM with one write port and two registered read ports.
module bra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/blep_ring_accumulator.sv
// Top level of the band-limited step correction mixer with its correction ring.
// A step transfer holds the block in the step state; its sample is written to the output register
// when the step fires, and the block waits there while that register is still full.
// A table write passes through the write state. An add passes through a setup state, reads one tap per
// cycle from the dual-read table memory, and then drains the multiply pipeline in a drain state.
// Reset clears the ring valid bits, so every ring word reads as zero, and the read pointer.
// The correction tables are not cleared and must be loaded before use.
module blep_ring_accumulator import bra_pkg::*; #(
  parameter int TAPS   = 64,
  parameter int PHASES = 64
) (
  input  logic      clk,
  input  logic      rst,
  bra_req_if.sink   request,
  bra_smp_if.source result
);

  localparam int PTR_W     = $clog2(TAPS);
  localparam int CNT_W     = $clog2(TAPS + 1);
  localparam int TBL_WORDS = (PHASES + 1) * TAPS;
  localparam int TBL_DEPTH = 3 * TBL_WORDS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int P_W       = POS_W + $clog2(PHASES + 1);
  localparam int PROW_W    = P_W - FRAC_W;
  localparam int W0_W      = FRAC_W + 1;
  localparam int PA_W      = VAL_W + W0_W + 1;
  localparam int T_W       = PA_W + 1;
  localparam int Q_W       = T_W + AMP_W;
  localparam int RND_SH    = 32;
  localparam int C_W       = Q_W - RND_SH;
  localparam int SUM_W     = SMP_W + 1;

  localparam logic signed [SMP_W-1:0] SAT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SAT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  state_t state;
  state_t state_next;

  logic                    ready_int;
  logic                    tbl_we;
  logic                    issue;
  logic                    step_fire;
  logic                    accept;

  logic signed [AMP_W-1:0] item_amp;
  logic [POS_W-1:0]        item_pos;
  logic [KIND_W-1:0]       item_kind;
  logic [ROW_W-1:0]        item_row;
  logic [TAP_W-1:0]        item_tap;
  logic [VAL_W-1:0]        item_val;

  logic [P_W-1:0]          p_prod;
  logic [PROW_W-1:0]       row_sel;
  logic [TBL_AW-1:0]       base_sel;
  logic [TBL_AW-1:0]       wr_addr;
  logic                    wr_in_range;

  logic [TBL_AW-1:0]       base0;
  logic [FRAC_W-1:0]       frac;
  logic [W0_W-1:0]         w0;
  logic [CNT_W-1:0]        cnt;
  logic [PTR_W-1:0]        issue_idx;
  logic [PTR_W-1:0]        rp;
  logic [TAPS-1:0]         ring_vld;

  logic [VAL_W-1:0]        tap_a;
  logic [VAL_W-1:0]        tap_b;
  logic [SMP_W-1:0]        ring_add;
  logic [SMP_W-1:0]        ring_step;

  logic                    s1_v, s2_v, s3_v, s4_v;
  logic [PTR_W-1:0]        s1_idx, s2_idx, s3_idx, s4_idx;
  logic signed [PA_W-1:0]  s2_pa, s2_pb;
  logic signed [T_W-1:0]   s3_t;
  logic signed [Q_W-1:0]   s4_q;
  logic                    s4_rv;

  logic signed [PA_W-1:0]  pa;
  logic signed [PA_W-1:0]  pb;
  logic signed [Q_W-1:0]   q_rnd;
  logic signed [C_W-1:0]   corr;
  logic signed [SMP_W-1:0] ring_old;
  logic signed [SUM_W-1:0] sum;
  logic signed [SMP_W-1:0] sum_sat;

  logic                    out_v;
  logic signed [SMP_W-1:0] out_sample;

  assign accept = request.valid && ready_int;
  assign request.ready = ready_int;
  assign result.valid  = out_v;
  assign result.sample = out_sample;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          case (req_kind_t'(request.req_type))
            REQ_STEP:  state_next = ST_STEP;
            REQ_ADD:   state_next = ST_SETUP;
            REQ_WRITE: state_next = ST_WRITE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_SETUP: state_next = ST_ADD;
      ST_ADD: begin
        if (cnt == CNT_W'(TAPS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(s1_v || s2_v || s3_v)) begin
          state_next = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (step_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready_int = 1'b0;
    tbl_we    = 1'b0;
    issue     = 1'b0;
    step_fire = 1'b0;
    case (state)
      ST_IDLE:  ready_int = 1'b1;
      ST_WRITE: tbl_we    = wr_in_range;
      ST_ADD:   issue     = 1'b1;
      ST_STEP:  step_fire = !out_v || result.ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    p_prod   = P_W'(item_pos) * P_W'(PHASES);
    row_sel  = p_prod[P_W-1:FRAC_W];
    base_sel = TBL_AW'(kind_sel(item_kind)) * TBL_AW'(TBL_WORDS)
               + TBL_AW'(row_sel) * TBL_AW'(TAPS);
    wr_addr  = TBL_AW'(kind_sel(item_kind)) * TBL_AW'(TBL_WORDS)
               + TBL_AW'(item_row) * TBL_AW'(TAPS) + TBL_AW'(item_tap);
    wr_in_range = (32'(item_row) <= PHASES) && (32'(item_tap) < TAPS);
  end

  bra_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (wr_addr),
    .wdata   (item_val),
    .raddr_a (base0 + TBL_AW'(cnt)),
    .rdata_a (tap_a),
    .raddr_b (base0 + TBL_AW'(TAPS) + TBL_AW'(cnt)),
    .rdata_b (tap_b)
  );

  bra_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_ring (
    .clk     (clk),
    .we      (s4_v),
    .waddr   (s4_idx),
    .wdata   (sum_sat),
    .raddr_a (s3_idx),
    .rdata_a (ring_add),
    .raddr_b (rp),
    .rdata_b (ring_step)
  );

  // Interpolation weights, scaling, rounding half up and saturating accumulation.
  always_comb begin
    w0       = W0_W'(1 << FRAC_W) - W0_W'(frac);
    pa       = $signed(tap_a) * $signed({1'b0, w0});
    pb       = $signed(tap_b) * $signed({2'b00, frac});
    q_rnd    = s4_q + (Q_W'(1) << (RND_SH - 1));
    corr     = q_rnd[Q_W-1:RND_SH];
    ring_old = s4_rv ? $signed(ring_add) : '0;
    sum      = SUM_W'(ring_old) + SUM_W'(corr);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sum_sat = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_sat = sum[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      s4_v     <= 1'b0;
      cnt      <= '0;
      rp       <= '0;
      ring_vld <= '0;
      out_v    <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= issue;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      s4_v  <= s3_v;
      if (state == ST_SETUP) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (s4_v) begin
        ring_vld[s4_idx] <= 1'b1;
      end
      if (step_fire) begin
        ring_vld[rp] <= 1'b0;
        rp <= (rp == PTR_W'(TAPS - 1)) ? '0 : rp + PTR_W'(1);
        out_v <= 1'b1;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_amp  <= request.amplitude;
      item_pos  <= request.position;
      item_kind <= request.kind;
      item_row  <= request.table_row;
      item_tap  <= request.table_tap;
      item_val  <= request.table_value;
    end
    if (state == ST_SETUP) begin
      base0     <= base_sel;
      frac      <= p_prod[FRAC_W-1:0];
      issue_idx <= rp;
    end else if (issue) begin
      issue_idx <= (issue_idx == PTR_W'(TAPS - 1)) ? '0 : issue_idx + PTR_W'(1);
    end
    s1_idx <= issue_idx;
    s2_idx <= s1_idx;
    s2_pa  <= pa;
    s2_pb  <= pb;
    s3_idx <= s2_idx;
    s3_t   <= T_W'(s2_pa) + T_W'(s2_pb);
    s4_idx <= s3_idx;
    s4_q   <= s3_t * item_amp;
    s4_rv  <= ring_vld[s3_idx];
    if (step_fire) begin
      out_sample <= ring_vld[rp] ? $signed(ring_step) : '0;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !(s1_v || s2_v || s3_v || s4_v))
    else $error("Multiply pipeline holds work while idle.");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> cnt == CNT_W'(TAPS))
    else $error("Add did not issue every tap before draining.");

  a_rp_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(rp) |-> $past(state == ST_STEP))
    else $error("Read pointer moved outside a step.");

  a_out_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_v) |-> $past(state == ST_STEP))
    else $error("Sample transfer offered without a step.");

  a_ring_write_in_add: assert property (@(posedge clk) disable iff (rst)
    s4_v |-> (state == ST_ADD || state == ST_DRAIN))
    else $error("Ring write outside an add.");

endmodule
